### rtl/dbcw_pkg.sv
// Package for the delay based congestion window core.
// Holds request, response, configuration and queue types, codes and reset constants.
// No dependencies.
package dbcw_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_NUM_WIDTH = 64;
   localparam int DIV_DEN_WIDTH = 48;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_NUM_WIDTH);
   localparam int SQRT_IN_WIDTH = 64;
   localparam int SQRT_OUT_WIDTH = SQRT_IN_WIDTH / 2;
   localparam int SQRT_CNT_WIDTH = $clog2(SQRT_OUT_WIDTH);

   localparam logic [15:0] RST_MSS     = 16'd1500;
   localparam logic [31:0] RST_BASE    = 32'd25000;
   localparam logic [31:0] RST_ALPHA   = 32'd0;
   localparam logic [31:0] RST_BETA    = 32'd0;
   localparam logic [31:0] RST_RANGE   = 32'd0;
   localparam logic [15:0] RST_MAX_MDF = 16'd32768;
   localparam logic [15:0] RST_MD_BETA = 16'd52429;
   localparam logic [15:0] RST_AI_GAIN = 16'd256;
   localparam logic [31:0] RST_WINDOW  = 32'd15000;

   localparam logic [16:0] ONE_Q16     = 17'h10000;
   localparam logic [31:0] SAT_MAX     = 32'hFFFF_FFFF;
   localparam logic [7:0]  RTX_MAX     = 8'hFF;

   typedef enum logic [2:0] {
      CSR_MSS       = 3'd0,
      CSR_BASE      = 3'd1,
      CSR_ALPHA     = 3'd2,
      CSR_BETA      = 3'd3,
      CSR_RANGE     = 3'd4,
      CSR_MAX_MDF   = 3'd5,
      CSR_MD_BETA   = 3'd6,
      CSR_AI_GAIN   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NACK    = 2'd0,
      KIND_TIMEOUT = 2'd1,
      KIND_ACK     = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_TOTAL,
      ST_CLASS,
      ST_DIV1,
      ST_SQRT,
      ST_DIV2,
      ST_TGT,
      ST_CMP,
      ST_AI2,
      ST_AI3,
      ST_DIV4,
      ST_MD,
      ST_DIV3,
      ST_CUT,
      ST_SCALE
   } back_state_type;

   typedef struct packed {
      logic [15:0] nack_count;
      logic [15:0] timeout_count;
      logic [15:0] ack_count;
      logic [31:0] rtt_sample;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [31:0] window_bytes;
      logic        status;
      logic        nack_consumed;
      logic        timeout_consumed;
      logic [15:0] acks_consumed;
      logic        window_decreased;
   } rsp_type;

   typedef struct packed {
      logic [15:0] mss;
      logic [31:0] base_delay;
      logic [31:0] flow_alpha;
      logic [31:0] fs_beta;
      logic [31:0] flow_cap;
      logic [15:0] max_mdf;
      logic [15:0] md_beta;
      logic [15:0] ai_gain;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] acks;
      logic [31:0] rtt;
      logic [31:0] now;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic                     start;
      logic [DIV_NUM_WIDTH-1:0] num;
      logic [DIV_DEN_WIDTH-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                     busy;
      logic [DIV_NUM_WIDTH-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic                     start;
      logic [SQRT_IN_WIDTH-1:0] x;
   } sqrt_req_type;

   typedef struct packed {
      logic                      busy;
      logic [SQRT_OUT_WIDTH-1:0] root;
   } sqrt_rsp_type;

endpackage

### rtl/dbcw_front.sv
// Front end: accepts requests, classifies them by event kind, queues them.
// Depends on dbcw_pkg.
module dbcw_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  dbcw_pkg::req_type      req_data,
   input  logic                   q_pop,
   output dbcw_pkg::queue_out_type q_out
);
   import dbcw_pkg::*;

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   item_type              item_new;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      if (req_data.nack_count != 16'd0) begin
         item_new.kind = KIND_NACK;
      end else if (req_data.timeout_count != 16'd0) begin
         item_new.kind = KIND_TIMEOUT;
      end else begin
         item_new.kind = KIND_ACK;
      end
      item_new.acks = req_data.ack_count;
      item_new.rtt  = req_data.rtt_sample;
      item_new.now  = req_data.now_time;
   end

   assign req_full    = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign do_push     = req_push && !req_full;
   assign do_pop      = q_pop && (count_ff != '0);
   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

### rtl/dbcw_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on dbcw_pkg.
module dbcw_div (
   input  logic                  clock,
   input  logic                  reset,
   input  dbcw_pkg::div_req_type div_req,
   output dbcw_pkg::div_rsp_type div_rsp
);
   import dbcw_pkg::*;

   logic                     busy_ff, busy_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_WIDTH:0]   rem_ff, rem_in;
   logic [DIV_NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [DIV_DEN_WIDTH-1:0] den_ff, den_in;
   logic [DIV_DEN_WIDTH:0]   rem_sh;
   logic                     fit;

   assign rem_sh = {rem_ff[DIV_DEN_WIDTH-1:0], quo_ff[DIV_NUM_WIDTH-1]};
   assign fit    = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (busy_ff) begin
         rem_in = fit ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_in = {quo_ff[DIV_NUM_WIDTH-2:0], fit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(DIV_NUM_WIDTH - 1)) begin
            busy_in = 1'b0;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.quot = quo_ff;

endmodule

### rtl/dbcw_sqrt.sv
// Integer square root, one result bit per cycle.
// Depends on dbcw_pkg.
module dbcw_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  dbcw_pkg::sqrt_req_type sqrt_req,
   output dbcw_pkg::sqrt_rsp_type sqrt_rsp
);
   import dbcw_pkg::*;

   logic                      busy_ff, busy_in;
   logic [SQRT_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [SQRT_IN_WIDTH-1:0]  x_ff, x_in;
   logic [SQRT_OUT_WIDTH+2:0] rem_ff, rem_in;
   logic [SQRT_OUT_WIDTH-1:0] root_ff, root_in;
   logic [SQRT_OUT_WIDTH+2:0] rem_sh;
   logic [SQRT_OUT_WIDTH+2:0] trial;

   assign rem_sh = {rem_ff[SQRT_OUT_WIDTH:0], x_ff[SQRT_IN_WIDTH-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (busy_ff) begin
         x_in = {x_ff[SQRT_IN_WIDTH-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[SQRT_OUT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[SQRT_OUT_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQRT_CNT_WIDTH'(SQRT_OUT_WIDTH - 1)) begin
            busy_in = 1'b0;
         end
      end else if (sqrt_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = sqrt_req.x;
         rem_in  = '0;
         root_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sqrt_rsp.busy = busy_ff;
   assign sqrt_rsp.root = root_ff;

endmodule

### rtl/dbcw_back.sv
// Back end: sequencer that applies one queued request to the window state.
// Depends on dbcw_pkg; drives the shared dbcw_div and dbcw_sqrt units.
module dbcw_back #(
   parameter int RTX_RESET_LIMIT = 5,
   parameter int TIME_WIDTH      = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dbcw_pkg::cfg_type       cfg,
   input  dbcw_pkg::queue_out_type q_out,
   output logic                    q_pop,
   output dbcw_pkg::div_req_type   div_req,
   input  dbcw_pkg::div_rsp_type   div_rsp,
   output dbcw_pkg::sqrt_req_type  sqrt_req,
   input  dbcw_pkg::sqrt_rsp_type  sqrt_rsp,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output dbcw_pkg::rsp_type       rsp_data
);
   import dbcw_pkg::*;

   back_state_type state_ff, state_in;
   logic [31:0] window_ff, window_in;
   logic [31:0] acked_ff, acked_in;
   logic [31:0] ldt_ff, ldt_in;
   logic [7:0]  rtx_ff, rtx_in;
   logic [31:0] est_ff, est_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   item_type    item_ff, item_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] total_ff, total_in;
   logic        can_dec_ff, can_dec_in;
   logic        noev_ff, noev_in;
   logic        fin_ff, fin_in;
   logic [31:0] w_new_ff, w_new_in;
   logic [16:0] factor_ff, factor_in;
   logic [48:0] mul_ff, mul_in;
   logic [31:0] fs_ff, fs_in;
   logic [32:0] tgt_ff, tgt_in;
   logic [63:0] p64_ff, p64_in;

   logic [15:0] mss_e;
   logic [16:0] cut;
   logic [32:0] tot_sum;
   logic [63:0] tdiff64;
   logic [TIME_WIDTH-1:0] tdiff;
   logic        can_dec_now;
   logic [34:0] est7;
   logic [31:0] est_next;
   logic [7:0]  rtx_inc;
   logic [31:0] w_nz;
   logic [31:0] s_nz;
   logic signed [49:0] fs_s;
   logic [32:0] ai_sum;
   logic [16:0] f_dec;
   logic [32:0] scaled;
   logic        slot_free;

   assign mss_e   = (cfg.mss == 16'd0) ? 16'd1 : cfg.mss;
   assign cut     = ONE_Q16 - {1'b0, cfg.max_mdf};
   assign tot_sum = {1'b0, acked_ff} + {1'b0, prod_ff};
   assign tdiff64 = {32'd0, item_ff.now} - {32'd0, ldt_ff};
   assign tdiff   = tdiff64[TIME_WIDTH-1:0];
   assign can_dec_now = (64'(tdiff) >= {32'd0, est_ff});
   assign est7    = {3'd0, est_ff} * 35'd7;
   assign est_next = (est_ff == 32'd0) ? item_ff.rtt
                   : est7[34:3] + {3'd0, item_ff.rtt[31:3]};
   assign rtx_inc = (rtx_ff == RTX_MAX) ? rtx_ff : rtx_ff + 8'd1;
   assign w_nz    = (window_ff == 32'd0) ? 32'd1 : window_ff;
   assign s_nz    = (sqrt_rsp.root == '0) ? 32'd1 : sqrt_rsp.root;
   assign fs_s    = $signed({2'b00, div_rsp.quot[47:0]})
                  + 50'(signed'(cfg.fs_beta));
   assign ai_sum  = {1'b0, window_ff} + {1'b0, div_rsp.quot[31:0]};
   assign f_dec   = ONE_Q16 - div_rsp.quot[16:0];
   assign scaled  = mul_ff[48:16];
   assign slot_free = !rsp_valid_ff || rsp_pop;

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      acked_in     = acked_ff;
      ldt_in       = ldt_ff;
      rtx_in       = rtx_ff;
      est_in       = est_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      item_in      = item_ff;
      prod_in      = prod_ff;
      total_in     = total_ff;
      can_dec_in   = can_dec_ff;
      noev_in      = noev_ff;
      fin_in       = 1'b0;
      w_new_in     = w_new_ff;
      factor_in    = factor_ff;
      mul_in       = mul_ff;
      fs_in        = fs_ff;
      tgt_in       = tgt_ff;
      p64_in       = p64_ff;
      q_pop        = 1'b0;
      div_req.start  = 1'b0;
      div_req.num    = {window_ff, 32'd0};
      div_req.den    = 48'(mss_e);
      sqrt_req.start = 1'b0;
      sqrt_req.x     = div_rsp.quot;

      case (state_ff)
         ST_IDLE: begin
            if (q_out.valid && !fin_ff) begin
               q_pop    = 1'b1;
               item_in  = q_out.item;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = {16'd0, item_ff.acks} * {16'd0, mss_e};
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            total_in = tot_sum[32] ? SAT_MAX : tot_sum[31:0];
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            w_new_in = window_ff;
            if (item_ff.kind == KIND_ACK && total_ff == 32'd0) begin
               noev_in  = 1'b1;
               fin_in   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               noev_in    = 1'b0;
               can_dec_in = can_dec_now;
               est_in     = est_next;
               case (item_ff.kind)
                  KIND_NACK: begin
                     rtx_in = 8'd0;
                     if (can_dec_now) begin
                        factor_in = cut;
                        state_in  = ST_CUT;
                     end else begin
                        fin_in   = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
                  KIND_TIMEOUT: begin
                     rtx_in = rtx_inc;
                     if (rtx_inc >= 8'(RTX_RESET_LIMIT)) begin
                        w_new_in = {16'd0, mss_e};
                        fin_in   = 1'b1;
                        state_in = ST_IDLE;
                     end else if (can_dec_now) begin
                        factor_in = cut;
                        state_in  = ST_CUT;
                     end else begin
                        fin_in   = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
                  default: begin
                     rtx_in = 8'd0;
                     if (window_ff == 32'd0) begin
                        fs_in    = 32'd0;
                        state_in = ST_TGT;
                     end else begin
                        div_req.start = 1'b1;
                        state_in      = ST_DIV1;
                     end
                  end
               endcase
            end
         end
         ST_DIV1: begin
            if (!div_rsp.busy) begin
               sqrt_req.start = 1'b1;
               state_in       = ST_SQRT;
            end
         end
         ST_SQRT: begin
            div_req.num = {16'd0, cfg.flow_alpha, 16'd0};
            div_req.den = {16'd0, s_nz};
            if (!sqrt_rsp.busy) begin
               div_req.start = 1'b1;
               state_in      = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (!div_rsp.busy) begin
               if (fs_s > $signed({18'd0, cfg.flow_cap})) begin
                  fs_in = cfg.flow_cap;
               end else if (fs_s < 0) begin
                  fs_in = 32'd0;
               end else begin
                  fs_in = fs_s[31:0];
               end
               state_in = ST_TGT;
            end
         end
         ST_TGT: begin
            tgt_in   = {1'b0, cfg.base_delay} + {1'b0, fs_ff};
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ({1'b0, item_ff.rtt} < tgt_ff) begin
               p64_in   = {32'd0, {16'd0, mss_e} * {16'd0, cfg.ai_gain}};
               state_in = ST_AI2;
            end else if (can_dec_ff) begin
               if (item_ff.rtt == 32'd0) begin
                  factor_in = ONE_Q16;
                  state_in  = ST_CUT;
               end else begin
                  p64_in   = {16'd0, {32'd0, cfg.md_beta}
                                    * {16'd0, item_ff.rtt - tgt_ff[31:0]}};
                  state_in = ST_MD;
               end
            end else begin
               fin_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_AI2: begin
            p64_in   = {32'd0, p64_ff[31:0]} * {32'd0, total_ff};
            state_in = ST_AI3;
         end
         ST_AI3: begin
            div_req.num   = p64_ff;
            div_req.den   = {8'd0, w_nz, 8'd0};
            div_req.start = 1'b1;
            state_in      = ST_DIV4;
         end
         ST_DIV4: begin
            if (!div_rsp.busy) begin
               if (div_rsp.quot[63:32] != 32'd0 || ai_sum[32]) begin
                  w_new_in = SAT_MAX;
               end else begin
                  w_new_in = ai_sum[31:0];
               end
               fin_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MD: begin
            div_req.num   = p64_ff;
            div_req.den   = {16'd0, item_ff.rtt};
            div_req.start = 1'b1;
            state_in      = ST_DIV3;
         end
         ST_DIV3: begin
            if (!div_rsp.busy) begin
               factor_in = (f_dec < cut) ? cut : f_dec;
               state_in  = ST_CUT;
            end
         end
         ST_CUT: begin
            mul_in   = {17'd0, window_ff} * {32'd0, factor_ff};
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            w_new_in = (scaled < {17'd0, mss_e}) ? {16'd0, mss_e} : scaled[31:0];
            fin_in   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold the finished request until the response slot frees
      if (fin_ff) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_in.window_bytes     = noev_ff ? window_ff : w_new_ff;
            rsp_in.status           = noev_ff;
            rsp_in.nack_consumed    = !noev_ff && (item_ff.kind == KIND_NACK);
            rsp_in.timeout_consumed = !noev_ff && (item_ff.kind == KIND_TIMEOUT);
            rsp_in.acks_consumed    = noev_ff ? 16'd0 : item_ff.acks;
            rsp_in.window_decreased = !noev_ff && (w_new_ff < window_ff);
            if (!noev_ff) begin
               window_in = w_new_ff;
               if (w_new_ff < window_ff) begin
                  ldt_in   = item_ff.now;
                  acked_in = 32'd0;
               end else begin
                  acked_in = total_ff;
               end
            end
         end else begin
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= RST_WINDOW;
         acked_ff     <= 32'd0;
         ldt_ff       <= 32'd0;
         rtx_ff       <= 8'd0;
         est_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         acked_ff     <= acked_in;
         ldt_ff       <= ldt_in;
         rtx_ff       <= rtx_in;
         est_ff       <= est_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_ff       <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      item_ff    <= item_in;
      prod_ff    <= prod_in;
      total_ff   <= total_in;
      can_dec_ff <= can_dec_in;
      noev_ff    <= noev_in;
      w_new_ff   <= w_new_in;
      factor_ff  <= factor_in;
      mul_ff     <= mul_in;
      fs_ff      <= fs_in;
      tgt_ff     <= tgt_in;
      p64_ff     <= p64_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/delay_based_congestion_window_core.sv
// Delay based congestion window core: one response per request.
// Latency with the back end idle is shortest for empty requests and for NACK or timeout
// requests that leave or reset the window, longer when they cut it, and longest for ACK
// requests (three divider passes and a square root set the worst case).
// One request at a time, after the last response is out; a two-entry queue holds two more.
// Synchronous active-high reset loads register defaults and a 15000 byte window.
module delay_based_congestion_window_core #(
   parameter int RTX_RESET_LIMIT = 5,
   parameter int TIME_WIDTH      = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  dbcw_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output dbcw_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import dbcw_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   queue_out_type q_out;
   logic          q_pop;
   div_req_type   div_req;
   div_rsp_type   div_rsp;
   sqrt_req_type  sqrt_req;
   sqrt_rsp_type  sqrt_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MSS:     cfg_in.mss        = csr_wdata[15:0];
            CSR_BASE:    cfg_in.base_delay = csr_wdata;
            CSR_ALPHA:   cfg_in.flow_alpha = csr_wdata;
            CSR_BETA:    cfg_in.fs_beta    = csr_wdata;
            CSR_RANGE:   cfg_in.flow_cap   = csr_wdata;
            CSR_MAX_MDF: cfg_in.max_mdf    = csr_wdata[15:0];
            CSR_MD_BETA: cfg_in.md_beta    = csr_wdata[15:0];
            CSR_AI_GAIN: cfg_in.ai_gain    = csr_wdata[15:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mss        <= RST_MSS;
         cfg_ff.base_delay <= RST_BASE;
         cfg_ff.flow_alpha <= RST_ALPHA;
         cfg_ff.fs_beta    <= RST_BETA;
         cfg_ff.flow_cap   <= RST_RANGE;
         cfg_ff.max_mdf    <= RST_MAX_MDF;
         cfg_ff.md_beta    <= RST_MD_BETA;
         cfg_ff.ai_gain    <= RST_AI_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dbcw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_pop    (q_pop),
      .q_out    (q_out)
   );

   dbcw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dbcw_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   dbcw_back #(
      .RTX_RESET_LIMIT (RTX_RESET_LIMIT),
      .TIME_WIDTH      (TIME_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .sqrt_req  (sqrt_req),
      .sqrt_rsp  (sqrt_rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_noev_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status) |->
         (!rsp_data.window_decreased && rsp_data.acks_consumed == 16'd0
          && !rsp_data.nack_consumed && !rsp_data.timeout_consumed))
      else $error("empty-event response carries event fields");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> $onehot0({rsp_data.nack_consumed, rsp_data.timeout_consumed}))
      else $error("response consumes both NACK and timeout");

   a_window_nz: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.window_bytes != 32'd0))
      else $error("window dropped to zero");

   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      !(div_rsp.busy && sqrt_rsp.busy))
      else $error("divider and square root busy together");

endmodule
